FILE: src/maw_pkg.sv
// Package for the moving average window unit.
// Sizes, shared types and the window size clamp; no dependencies.
package maw_pkg;

   // Ring depth and sample format
   localparam int DEPTH       = 64;
   localparam int SAMPLE_BITS = 16;

   // Derived widths
   localparam int POS_BITS     = $clog2(DEPTH);
   localparam int SIZE_BITS    = $clog2(DEPTH + 1);
   localparam int SUM_BITS     = SAMPLE_BITS + POS_BITS;
   localparam int DIV_CNT_BITS = $clog2(SUM_BITS + 1);

   // Queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // Window size after reset
   localparam logic [SIZE_BITS-1:0] WINDOW_RESET = SIZE_BITS'((64 > DEPTH) ? DEPTH : 64);

   // One update handed from the front to the divider
   typedef struct packed {
      logic signed [SUM_BITS-1:0] sum;
      logic [SIZE_BITS-1:0]       count;
      logic                       full;
   } sum_entry_type;

   typedef enum logic {
      F_IDLE,
      F_UPDATE
   } front_state_type;

   typedef enum logic [1:0] {
      B_IDLE,
      B_DIV,
      B_DONE
   } back_state_type;

   // Zero reads as one, anything above the depth saturates
   function automatic logic [SIZE_BITS-1:0] clamp_window(input logic [SIZE_BITS-1:0] value);
      logic [SIZE_BITS-1:0] result;
      result = value;
      if (value == '0) begin
         result = SIZE_BITS'(1);
      end else if (value > SIZE_BITS'(DEPTH)) begin
         result = SIZE_BITS'(DEPTH);
      end
      return result;
   endfunction

endpackage

FILE: src/maw_front.sv
// Front end of the moving average window unit: sample ring, fill count, running sum.
// Depends on maw_pkg. Hands each updated sum to the queue.
module maw_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [maw_pkg::SIZE_BITS-1:0]       csr_write_data,
   input  logic                                push,
   output logic                                full,
   input  logic signed [maw_pkg::SAMPLE_BITS-1:0] sample,
   input  logic                                q_room,
   output logic                                q_push,
   output maw_pkg::sum_entry_type              q_data
);
   import maw_pkg::*;

   front_state_type             state_ff, state_in;
   logic [SIZE_BITS-1:0]        window_ff, window_in;
   logic [POS_BITS-1:0]         wpos_ff, wpos_in;
   logic [SIZE_BITS-1:0]        fill_ff, fill_in;
   logic signed [SUM_BITS-1:0]  sum_ff, sum_in;
   logic [POS_BITS-1:0]         pos_ff, pos_in;
   logic signed [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic signed [SAMPLE_BITS-1:0] old_sample_ff;
   logic [POS_BITS-1:0]         rd_pos;
   logic [SIZE_BITS-1:0]        pos_next;
   logic                        accept;
   logic                        was_full;
   logic signed [SUM_BITS-1:0]  drop;

   logic signed [SAMPLE_BITS-1:0] ring_mem [DEPTH];

   // Slot for this sample: guard a stale position against the window size
   assign rd_pos = (SIZE_BITS'(wpos_ff) >= window_ff) ? '0 : wpos_ff;

   assign accept = push && !full;
   assign full   = (state_ff != F_IDLE) || !q_room;

   // Ring read (registered) and write
   always_ff @(posedge clock) begin
      old_sample_ff <= ring_mem[rd_pos];
      if (state_ff == F_UPDATE) begin
         ring_mem[pos_ff] <= sample_ff;
      end
   end

   assign was_full = (fill_ff >= window_ff);
   assign drop     = was_full ? SUM_BITS'(old_sample_ff) : '0;
   assign pos_next = SIZE_BITS'(pos_ff) + SIZE_BITS'(1);

   // Next state and update of window state
   always_comb begin
      state_in  = state_ff;
      window_in = window_ff;
      wpos_in   = wpos_ff;
      fill_in   = fill_ff;
      sum_in    = sum_ff;
      pos_in    = pos_ff;
      sample_in = sample_ff;
      q_push    = 1'b0;
      q_data.sum   = sum_ff - drop + SUM_BITS'(sample_ff);
      q_data.count = was_full ? fill_ff : fill_ff + SIZE_BITS'(1);
      q_data.full  = (q_data.count == window_ff);
      case (state_ff)
         F_IDLE: begin
            if (accept) begin
               pos_in    = rd_pos;
               sample_in = sample;
               state_in  = F_UPDATE;
            end
         end
         F_UPDATE: begin
            q_push   = 1'b1;
            sum_in   = q_data.sum;
            fill_in  = q_data.count;
            wpos_in  = (pos_next >= window_ff) ? '0 : POS_BITS'(pos_next);
            state_in = F_IDLE;
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
      // Any register write restarts the window
      if (csr_write_enable) begin
         window_in = clamp_window(csr_write_data);
         wpos_in   = '0;
         fill_in   = '0;
         sum_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= F_IDLE;
         window_ff <= WINDOW_RESET;
         wpos_ff   <= '0;
         fill_ff   <= '0;
         sum_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         window_ff <= window_in;
         wpos_ff   <= wpos_in;
         fill_ff   <= fill_in;
         sum_ff    <= sum_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      pos_ff    <= pos_in;
      sample_ff <= sample_in;
   end

endmodule

FILE: src/maw_queue.sv
// Short queue between the front end and the divider of the moving average unit.
// Depends on maw_pkg for the entry type and depth.
module maw_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_push,
   input  maw_pkg::sum_entry_type q_data,
   output logic                   q_room,
   input  logic                   q_pop,
   output logic                   q_empty,
   output maw_pkg::sum_entry_type q_head
);
   import maw_pkg::*;

   sum_entry_type          entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]   count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign q_room  = (count_ff != QCNT_BITS'(QUEUE_DEPTH));
   assign q_empty = (count_ff == '0);
   assign q_head  = entry_ff[rd_ptr_ff];
   assign do_push = q_push && q_room;
   assign do_pop  = q_pop && !q_empty;

   // Pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                     : wr_ptr_ff + QPTR_BITS'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                     : rd_ptr_ff + QPTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= q_data;
      end
   end

endmodule

FILE: src/maw_divider.sv
// Back end of the moving average unit: bit-serial signed divide of sum by count
// and the result register. Depends on maw_pkg.
module maw_divider (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                q_empty,
   input  maw_pkg::sum_entry_type              q_head,
   output logic                                q_pop,
   output logic                                empty,
   input  logic                                pop,
   output logic signed [maw_pkg::SAMPLE_BITS-1:0] rsp_mean,
   output logic [maw_pkg::SIZE_BITS-1:0]       rsp_samples_held,
   output logic                                rsp_window_full
);
   import maw_pkg::*;

   back_state_type            state_ff, state_in;
   logic [DIV_CNT_BITS-1:0]   step_ff, step_in;
   logic [SUM_BITS-1:0]       quot_ff, quot_in;
   logic [SIZE_BITS-1:0]      rem_ff, rem_in;
   logic [SIZE_BITS-1:0]      divisor_ff, divisor_in;
   logic                      neg_ff, neg_in;
   logic                      full_ff, full_in;
   logic                      out_valid_ff, out_valid_in;
   logic signed [SAMPLE_BITS-1:0] mean_ff, mean_in;
   logic [SIZE_BITS-1:0]      held_ff, held_in;
   logic                      wfull_ff, wfull_in;
   logic [SIZE_BITS:0]        shifted;
   logic [SIZE_BITS+1:0]      trial;
   logic                      fits;
   logic [SUM_BITS-1:0]       magnitude;
   logic                      load_out;

   assign empty            = !out_valid_ff;
   assign rsp_mean         = mean_ff;
   assign rsp_samples_held = held_ff;
   assign rsp_window_full  = wfull_ff;

   // One restoring step: bring down the next dividend bit and try the divisor
   assign shifted = {rem_ff, quot_ff[SUM_BITS-1]};
   assign trial   = {1'b0, shifted} - {2'b00, divisor_ff};
   assign fits    = !trial[SIZE_BITS+1];

   assign magnitude = q_head.sum[SUM_BITS-1] ? SUM_BITS'(-q_head.sum) : SUM_BITS'(q_head.sum);

   // Sequencer
   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      neg_in     = neg_ff;
      full_in    = full_ff;
      q_pop      = 1'b0;
      load_out   = 1'b0;
      case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               q_pop      = 1'b1;
               quot_in    = magnitude;
               rem_in     = '0;
               divisor_in = q_head.count;
               neg_in     = q_head.sum[SUM_BITS-1];
               full_in    = q_head.full;
               step_in    = '0;
               state_in   = B_DIV;
            end
         end
         B_DIV: begin
            quot_in = {quot_ff[SUM_BITS-2:0], fits};
            rem_in  = fits ? trial[SIZE_BITS-1:0] : shifted[SIZE_BITS-1:0];
            step_in = step_ff + DIV_CNT_BITS'(1);
            if (step_ff == DIV_CNT_BITS'(SUM_BITS - 1)) begin
               state_in = B_DONE;
            end
         end
         B_DONE: begin
            if (!out_valid_ff || pop) begin
               load_out = 1'b1;
               state_in = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   // Result register
   always_comb begin
      out_valid_in = out_valid_ff;
      mean_in      = mean_ff;
      held_in      = held_ff;
      wfull_in     = wfull_ff;
      if (pop && out_valid_ff) begin
         out_valid_in = 1'b0;
      end
      if (load_out) begin
         out_valid_in = 1'b1;
         mean_in      = neg_ff ? SAMPLE_BITS'(-quot_ff) : SAMPLE_BITS'(quot_ff);
         held_in      = divisor_ff;
         wfull_in     = full_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      step_ff    <= step_in;
      quot_ff    <= quot_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      neg_ff     <= neg_in;
      full_ff    <= full_in;
      mean_ff    <= mean_in;
      held_ff    <= held_in;
      wfull_ff   <= wfull_in;
   end

endmodule

FILE: src/moving_average_window_unit.sv
// Moving average window unit: each pushed 16-bit signed sample enters a ring of the last
// window_size samples (1..64, reset 64) and yields one result: the window sum divided by
// the samples held, truncated toward zero, plus the count and a window-full flag. The
// front end takes a sample with a ring read, then a sum update. The divider is
// bit-serial, one quotient bit per cycle over the 22-bit sum; a result takes a pop from
// the queue, 22 divide steps and a result load, so the divider sets the sustained rate.
// A two-entry queue lets the front end keep accepting samples while the divider and
// a waiting result are busy. Writing csr_write_data restarts the window (0 reads as 1,
// values above 64 saturate to 64); write it only while the block is idle.
// Depends on maw_pkg, maw_front, maw_queue and maw_divider.
module moving_average_window_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write_enable,
   input  logic [maw_pkg::SIZE_BITS-1:0]          csr_write_data,
   input  logic                                   push,
   output logic                                   full,
   input  logic signed [maw_pkg::SAMPLE_BITS-1:0] req_sample,
   output logic                                   empty,
   input  logic                                   pop,
   output logic signed [maw_pkg::SAMPLE_BITS-1:0] rsp_mean,
   output logic [maw_pkg::SIZE_BITS-1:0]          rsp_samples_held,
   output logic                                   rsp_window_full
);
   import maw_pkg::*;

   logic          q_room;
   logic          q_push;
   sum_entry_type q_data;
   logic          q_pop;
   logic          q_empty;
   sum_entry_type q_head;

   maw_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .push             (push),
      .full             (full),
      .sample           (req_sample),
      .q_room           (q_room),
      .q_push           (q_push),
      .q_data           (q_data)
   );

   maw_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_push  (q_push),
      .q_data  (q_data),
      .q_room  (q_room),
      .q_pop   (q_pop),
      .q_empty (q_empty),
      .q_head  (q_head)
   );

   maw_divider u_divider (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (q_empty),
      .q_head           (q_head),
      .q_pop            (q_pop),
      .empty            (empty),
      .pop              (pop),
      .rsp_mean         (rsp_mean),
      .rsp_samples_held (rsp_samples_held),
      .rsp_window_full  (rsp_window_full)
   );

endmodule

FILE: src/maw_checker.sv
// Port-level checks for the moving average window unit, bound to the top level.
// Depends on maw_pkg and moving_average_window_unit.
module maw_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   push,
   input logic                                   full,
   input logic                                   empty,
   input logic                                   pop,
   input logic signed [maw_pkg::SAMPLE_BITS-1:0] rsp_mean,
   input logic [maw_pkg::SIZE_BITS-1:0]          rsp_samples_held,
   input logic                                   rsp_window_full
);
   import maw_pkg::*;

   // Nothing waits and the input is open right after reset
   a_reset_clear: assert property (@(posedge clock)
      reset |=> (empty && !full))
      else $error("queue not clear after reset");

   // Front end enters its update state on every accepted sample and reads full there
   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      (push && !full) |=> full)
      else $error("input open in the cycle after a transfer");

   // A shown result always holds at least one and at most DEPTH samples
   a_held_range: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_samples_held != '0 && rsp_samples_held <= SIZE_BITS'(DEPTH)))
      else $error("samples held out of range");

   // A result that is not taken stays put
   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_mean) && $stable(rsp_samples_held)
                            && $stable(rsp_window_full)))
      else $error("waiting result changed");

endmodule

bind moving_average_window_unit maw_checker u_maw_checker (
   .clock            (clock),
   .reset            (reset),
   .push             (push),
   .full             (full),
   .empty            (empty),
   .pop              (pop),
   .rsp_mean         (rsp_mean),
   .rsp_samples_held (rsp_samples_held),
   .rsp_window_full  (rsp_window_full)
);
